FILE: sv/gees_pkg.sv
// Shared types and constants for the GPIO edge event serializer.
package gees_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int INDEX_WIDTH    = 4;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // Register index codes, taken from address bit 2.
   localparam logic REG_RISING_MASK  = 1'b0;
   localparam logic REG_FALLING_MASK = 1'b1;

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [INDEX_WIDTH-1:0]  pin_index_type;

   typedef struct packed {
      sample_type rising_mask;
      sample_type falling_mask;
   } cfg_type;

   typedef struct packed {
      pin_index_type index;
      sample_type    onehot;
      logic          last;
   } pick_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

FILE: sv/gees_if.sv
// Valid/ready channel interfaces for sample words and event words.
interface gees_req_if import gees_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type pin_sample;

   modport source (output valid, output pin_sample, input ready);
   modport sink (input valid, input pin_sample, output ready);
endinterface

interface gees_rsp_if import gees_pkg::*; ();
   logic          valid;
   logic          ready;
   pin_index_type pin_index;
   logic          is_rising;
   logic          last_event;

   modport source (output valid, output pin_index, output is_rising, output last_event,
                   input ready);
   modport sink (input valid, input pin_index, input is_rising, input last_event,
                 output ready);
endinterface

FILE: sv/gees_csr.sv
// APB-style register bank holding the rising and falling edge enable masks.
module gees_csr import gees_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   sample_type rising_ff, rising_in;
   sample_type falling_ff, falling_in;
   logic       write_en;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite;

   always_comb begin
      rising_in  = rising_ff;
      falling_in = falling_ff;
      if (write_en) begin
         case (paddr[2])
            REG_RISING_MASK:  rising_in  = pwdata[SAMPLE_WIDTH-1:0];
            REG_FALLING_MASK: falling_in = pwdata[SAMPLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rising_ff  <= '0;
         falling_ff <= '0;
      end else begin
         rising_ff  <= rising_in;
         falling_ff <= falling_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_RISING_MASK:  prdata = CSR_DATA_WIDTH'(rising_ff);
         REG_FALLING_MASK: prdata = CSR_DATA_WIDTH'(falling_ff);
         default:          prdata = '0;
      endcase
   end

   assign cfg.rising_mask  = rising_ff;
   assign cfg.falling_mask = falling_ff;

endmodule

FILE: sv/gees_pick.sv
// Lowest-set-bit picker shared by every step of the event scan.
module gees_pick import gees_pkg::*; (
   input  sample_type pending,
   output pick_type   pick
);

   pin_index_type index;
   sample_type    onehot;

   always_comb begin
      index = '0;
      for (int i = SAMPLE_WIDTH - 1; i >= 0; i--) begin
         if (pending[i]) begin
            index = INDEX_WIDTH'(i);
         end
      end
      onehot = SAMPLE_WIDTH'(1) << index;
   end

   // The picked pin is the final event when nothing else stays pending.
   assign pick.index  = index;
   assign pick.onehot = onehot;
   assign pick.last   = ((pending & ~onehot) == '0);

endmodule

FILE: sv/gpio_edge_event_serializer_core.sv
// Top level of the GPIO edge event serializer: edge detect, scan sequencer and output word.
//
//   Channel   Direction  Handshake              Word contents
//   req_if    in         valid/ready            pin_sample[15:0]
//   rsp_if    out        valid/ready            pin_index[3:0], is_rising, last_event
//   APB       in         psel/penable/pwrite    rising_mask @ 0x0, falling_mask @ 0x4
//
// A sample word yields one event word per cycle for each enabled edge while rsp_if does
// not stall, at most 16 events per sample; the single lowest-set-bit picker walks the
// pending edge vector. A sample with no enabled edge yields nothing and leaves the block
// idle, ready for the next sample.
// Reset is synchronous and active high; it clears both masks, the stored sample, the
// pending vector and the output word's valid.
// The event word sits in an output register; a stall on rsp_if holds the scan but a new
// sample is taken as soon as the last event of the previous one is loaded.
module gpio_edge_event_serializer_core import gees_pkg::*; #(
   parameter int PIN_COUNT = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   gees_req_if.sink                  req_if,
   gees_rsp_if.source                rsp_if
);

   // Pins at or above PIN_COUNT never produce events; only the sampled pins exist.
   localparam int PIN_LIMIT = (PIN_COUNT < SAMPLE_WIDTH) ? PIN_COUNT : SAMPLE_WIDTH;
   localparam logic [SAMPLE_WIDTH-1:0] PIN_ENABLE =
      SAMPLE_WIDTH'((64'd1 << PIN_LIMIT) - 64'd1);

   cfg_type       cfg;
   pick_type      pick;

   state_type     state_ff, state_in;
   sample_type    prev_ff, prev_in;
   sample_type    pending_ff, pending_in;
   sample_type    level_ff, level_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pin_index_type rsp_index_ff, rsp_index_in;
   logic          rsp_rising_ff, rsp_rising_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          req_accept;
   logic          load_event;
   sample_type    fire;

   gees_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gees_pick u_pick (
      .pending (pending_ff),
      .pick    (pick)
   );

   // A pin fires when it changed and its new level matches an enabled edge direction.
   always_comb begin
      fire = (req_if.pin_sample ^ prev_ff) & PIN_ENABLE &
             ((req_if.pin_sample & cfg.rising_mask) | (~req_if.pin_sample & cfg.falling_mask));
   end

   // Sequencer outputs. During a scan, a new event is loaded whenever the output register is
   // free or is being emptied in this cycle.
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      load_event   = (state_ff == ST_SCAN) && (!rsp_valid_ff || rsp_if.ready);
   end

   assign req_accept = req_if.valid && req_if.ready;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (fire != '0)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (load_event && pick.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath next values.
   always_comb begin
      prev_in       = prev_ff;
      pending_in    = pending_ff;
      level_in      = level_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_rising_in = rsp_rising_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         prev_in    = req_if.pin_sample;
         level_in   = req_if.pin_sample;
         pending_in = fire;
      end else if (load_event) begin
         pending_in    = pending_ff & ~pick.onehot;
         rsp_valid_in  = 1'b1;
         rsp_index_in  = pick.index;
         rsp_rising_in = level_ff[pick.index];
         rsp_last_in   = pick.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_rising_ff <= rsp_rising_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pin_index  = rsp_index_ff;
   assign rsp_if.is_rising  = rsp_rising_ff;
   assign rsp_if.last_event = rsp_last_ff;

endmodule

FILE: sv/gees_checker.sv
// Port-level checker for the GPIO edge event serializer, bound to the top level.
module gees_checker import gees_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input pin_index_type rsp_pin_index,
   input logic          rsp_last_event
);

   // A stalled event word holds still.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pin_index)))
      else $error("stalled event word changed");

   // No new sample is taken while an event other than the last is on show.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_event) |-> !req_ready)
      else $error("sample taken in the middle of an event run");

   // Events of one run follow each other without a gap.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_event) |=> rsp_valid)
      else $error("gap inside an event run");

   // Within one run pins come out in increasing order.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_event) |=> (rsp_pin_index > $past(rsp_pin_index)))
      else $error("event run out of pin order");

   // Reset empties the output word.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("event word valid after reset");

endmodule

bind gpio_edge_event_serializer_core gees_checker u_gees_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_pin_index  (rsp_if.pin_index),
   .rsp_last_event (rsp_if.last_event)
);
